// ===== hw/rtl/q2e_pkg.sv =====
// ============================================================================
// q2e_pkg: shared constants for the quaternion to Euler converter.
// Holds the CORDIC arctangent table on a 32-bit turn.
// ============================================================================
`default_nettype none
package q2e_pkg;

  localparam int TurnWidth = 32;
  localparam int MaxSteps  = 32;

  // Arctangent of 2^-k as a fraction of a full turn, 2^32 = full circle.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    begin
      case (k)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029;
        5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003;
        5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/q2e_quat_if.sv =====
// ============================================================================
// q2e_quat_if: valid/ready channel carrying one quaternion word.
// ============================================================================
`default_nettype none
interface q2e_quat_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] comp_w;
  logic signed [COMPONENT_WIDTH-1:0] comp_x;
  logic signed [COMPONENT_WIDTH-1:0] comp_y;
  logic signed [COMPONENT_WIDTH-1:0] comp_z;

  modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/q2e_euler_if.sv =====
// ============================================================================
// q2e_euler_if: valid/ready channel carrying one Euler angle word.
// ============================================================================
`default_nettype none
interface q2e_euler_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  logic                          pitch_clamped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// ============================================================================
// quaternion_to_euler_angles: unit quaternion to roll, pitch and yaw.
// Pipelined products, square root and three CORDIC atan2 units.
// ============================================================================
// Throughput: one word per cycle; the unrolled CORDIC and bit-pair square
// root pipelines advance together, stalled as a whole by the output side.
// Reset: rst clears only the valid bits; the datapath registers are not reset.
`default_nettype none
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input wire logic clk,
  input wire logic rst,
  q2e_quat_if.sink    quat,
  q2e_euler_if.source euler
);

  localparam int FracBits  = COMPONENT_WIDTH - 2;
  localparam int ProdShift = (COMPONENT_WIDTH > 30) ? 2 : 0;
  localparam int OneExp    = 2 * FracBits - ProdShift;
  localparam int PW        = 2 * COMPONENT_WIDTH - ProdShift;
  // Sums of two products doubled, minus one: three extra bits cover it.
  localparam int SumW      = PW + 3;
  localparam int Q30W      = 31;
  localparam int CordLat   = CORDIC_STEPS + 2;

  // The whole pipeline advances when the output register is free or taken.
  logic en;
  assign en = !euler.valid || euler.ready;
  assign quat.ready = en;

  // Stage 1: products.
  logic                  p_vld;
  logic signed [PW-1:0]  p_zy, p_wx, p_xx, p_yy, p_zw, p_xy, p_ww, p_yw, p_zx;

  function automatic logic signed [PW-1:0] mul(
    input logic signed [COMPONENT_WIDTH-1:0] a,
    input logic signed [COMPONENT_WIDTH-1:0] b);
    logic signed [2*COMPONENT_WIDTH-1:0] m;
    begin
      m = a * b;
      return PW'(m >>> ProdShift);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= quat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_zy <= mul(quat.comp_z, quat.comp_y);
      p_wx <= mul(quat.comp_w, quat.comp_x);
      p_xx <= mul(quat.comp_x, quat.comp_x);
      p_yy <= mul(quat.comp_y, quat.comp_y);
      p_zw <= mul(quat.comp_z, quat.comp_w);
      p_xy <= mul(quat.comp_x, quat.comp_y);
      p_ww <= mul(quat.comp_w, quat.comp_w);
      p_yw <= mul(quat.comp_y, quat.comp_w);
      p_zx <= mul(quat.comp_z, quat.comp_x);
    end
  end

  // Stage 2: sums, pitch clamp.
  localparam logic signed [SumW-1:0] One = SumW'(1) <<< OneExp;

  logic                   s_vld, s_clamp;
  logic signed [SumW-1:0] s_rn, s_rd, s_yn, s_yd, s_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (en) begin
      s_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [SumW-1:0] s;
      s_rn <= (SumW'(p_zy) + SumW'(p_wx)) <<< 1;
      s_rd <= One - ((SumW'(p_xx) + SumW'(p_yy)) <<< 1);
      s_yn <= (SumW'(p_zw) + SumW'(p_xy)) <<< 1;
      s_yd <= ((SumW'(p_ww) + SumW'(p_xx)) <<< 1) - One;
      s = (SumW'(p_yw) - SumW'(p_zx)) <<< 1;
      if (s > One) begin
        s_s <= One;
        s_clamp <= 1'b1;
      end else if (s < -One) begin
        s_s <= -One;
        s_clamp <= 1'b1;
      end else begin
        s_s <= s;
        s_clamp <= 1'b0;
      end
    end
  end

  // Stage 3: sine magnitude in Q1.30 and its sign, its square, and the other operands.
  logic              t_vld, t_neg, t_clamp;
  logic [Q30W-1:0]   t_q30;
  logic [61:0]       t_sq;
  logic [60:0]       t_rad;
  logic signed [SumW-1:0] t_rn, t_rd, t_yn, t_yd;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (en) begin
      t_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [SumW+30:0] mag, q;
      mag = s_s[SumW-1] ? (SumW+31)'(-s_s) : (SumW+31)'(s_s);
      if (OneExp <= 30) begin
        q = mag << (30 - OneExp);
      end else begin
        q = (mag + ((SumW+31)'(1) << (OneExp - 31))) >> (OneExp - 30);
      end
      if (q > (SumW+31)'(1) << 30) begin
        q = (SumW+31)'(1) << 30;
      end
      t_q30 <= Q30W'(q);
      t_sq  <= 62'(q[Q30W-1:0]) * 62'(q[Q30W-1:0]);
      t_neg <= s_s[SumW-1];
      t_clamp <= s_clamp;
      t_rn <= s_rn;
      t_rd <= s_rd;
      t_yn <= s_yn;
      t_yd <= s_yd;
    end
  end

  // The square of q30 is registered apart from the subtraction feed.
  assign t_rad = 61'((62'd1 << 60) - t_sq);

  // Square root; the other atan2 operands ride along as its tag.
  localparam int TagW = 4 * SumW + Q30W + 2;
  logic            r_vld;
  logic [30:0]     r_c;
  logic [TagW-1:0] r_tag;

  q2e_isqrt #(
    .TAG_WIDTH(TagW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t_vld),
    .in_rad   (t_rad),
    .in_tag   ({t_rn, t_rd, t_yn, t_yd, t_q30, t_neg, t_clamp}),
    .out_valid(r_vld),
    .out_root (r_c),
    .out_tag  (r_tag)
  );

  logic signed [SumW-1:0] r_rn, r_rd, r_yn, r_yd;
  logic [Q30W-1:0]        r_q30;
  logic                   r_neg, r_clamp;
  assign {r_rn, r_rd, r_yn, r_yd, r_q30, r_neg, r_clamp} = r_tag;

  localparam int CW = (SumW > 33) ? SumW : 33;
  logic signed [CW-1:0] sq_s;
  assign sq_s = r_neg ? -CW'(r_q30) : CW'(r_q30);

  logic [ANGLE_WIDTH-1:0] roll_a, pitch_a, yaw_a;

  q2e_cordic #(.IN_WIDTH(SumW), .ANGLE_WIDTH(ANGLE_WIDTH), .STEPS(CORDIC_STEPS))
    u_roll (.clk(clk), .en(en), .in_y(r_rn), .in_x(r_rd), .angle(roll_a));
  q2e_cordic #(.IN_WIDTH(CW), .ANGLE_WIDTH(ANGLE_WIDTH), .STEPS(CORDIC_STEPS))
    u_pitch (.clk(clk), .en(en), .in_y(sq_s), .in_x(CW'(r_c)), .angle(pitch_a));
  q2e_cordic #(.IN_WIDTH(SumW), .ANGLE_WIDTH(ANGLE_WIDTH), .STEPS(CORDIC_STEPS))
    u_yaw (.clk(clk), .en(en), .in_y(r_yn), .in_x(r_yd), .angle(yaw_a));

  // Valid and clamp flag follow the CORDIC pipelines.
  logic [CordLat-1:0] c_vld, c_clamp;
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= '0;
    end else if (en) begin
      c_vld <= {c_vld[CordLat-2:0], r_vld};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_clamp <= {c_clamp[CordLat-2:0], r_clamp};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      euler.valid <= 1'b0;
    end else if (en) begin
      euler.valid <= c_vld[CordLat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_angle    <= roll_a;
      euler.pitch_angle   <= pitch_a;
      euler.yaw_angle     <= yaw_a;
      euler.pitch_clamped <= c_clamp[CordLat-1];
    end
  end

  // A stalled result must stay valid and keep its pitch angle until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    euler.valid && !euler.ready |=> euler.valid && $stable(euler.pitch_angle))
    else $error("result changed while stalled");

  // Pitch never leaves plus or minus a quarter turn.
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> ($signed(euler.pitch_angle) <= $signed(ANGLE_WIDTH'(1) << (ANGLE_WIDTH-2))
                     && $signed(euler.pitch_angle) >= -$signed(ANGLE_WIDTH'(1) << (ANGLE_WIDTH-2))))
    else $error("pitch out of range");

  // The input side is ready exactly when the pipeline may advance.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    quat.ready == (!euler.valid || euler.ready))
    else $error("ready mismatch");

endmodule
`default_nettype wire

// ===== hw/rtl/q2e_isqrt.sv =====
// ============================================================================
// q2e_isqrt: pipelined integer square root of 2^60 - q^2.
// Two result bits are resolved per register stage (16 stages).
// ============================================================================
`default_nettype none
module q2e_isqrt
  import q2e_pkg::*;
#(
  parameter int TAG_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [60:0]          in_rad,
  input  wire logic [TAG_WIDTH-1:0] in_tag,
  output logic                      out_valid,
  output logic [30:0]               out_root,
  output logic [TAG_WIDTH-1:0]      out_tag
);

  localparam int Stages = 16;
  localparam int PerStage = 2;

  logic [Stages:0]        vld;
  logic [61:0]            rem  [Stages+1];
  logic [31:0]            res  [Stages+1];
  logic [TAG_WIDTH-1:0]   tag  [Stages+1];

  assign vld[0] = in_valid;
  assign rem[0] = {1'b0, in_rad};
  assign res[0] = '0;
  assign tag[0] = in_tag;

  // Bit-pair method: the result holds the root bits found so far. The first
  // pair sits at bits 63:62, which are always zero, so the top root bit is 0.
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [61:0] r_n;
    logic [31:0] q_n;
    always_comb begin
      logic [63:0] trial;
      logic [61:0] r_w;
      logic [31:0] q_w;
      r_w = rem[s];
      q_w = res[s];
      for (int j = 0; j < PerStage; j++) begin
        trial = {q_w, 2'b01} << (62 - 2 * (s * PerStage + j));
        if ({2'b00, r_w} >= trial) begin
          r_w = r_w - trial[61:0];
          q_w = {q_w[30:0], 1'b1};
        end else begin
          q_w = {q_w[30:0], 1'b0};
        end
      end
      r_n = r_w;
      q_n = q_w;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_n;
        res[s+1] <= q_n;
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign out_root  = res[Stages][30:0];
  assign out_tag   = tag[Stages];

endmodule
`default_nettype wire

// ===== hw/rtl/q2e_cordic.sv =====
// ============================================================================
// q2e_cordic: pipelined vectoring CORDIC atan2 on a 32-bit turn.
// Normalizes, folds into the right half plane, then one rotation per stage.
// ============================================================================
`default_nettype none
module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int IN_WIDTH    = 36,
  parameter int ANGLE_WIDTH = 16,
  parameter int STEPS       = 16
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [IN_WIDTH-1:0] in_y,
  input  wire logic signed [IN_WIDTH-1:0] in_x,
  output logic [ANGLE_WIDTH-1:0]          angle
);

  localparam int MagW = IN_WIDTH + 1;
  localparam int LzW  = $clog2(MagW + 1);
  localparam int SW   = 33;

  // Stage A: magnitude and leading bit position.
  function automatic logic [MagW-1:0] mag_of(input logic signed [IN_WIDTH-1:0] v);
    logic signed [MagW-1:0] e;
    begin
      e = MagW'(v);
      return v[IN_WIDTH-1] ? MagW'(-e) : MagW'(e);
    end
  endfunction

  logic signed [IN_WIDTH-1:0] a_y, a_x;
  logic [LzW-1:0]             a_msb;
  logic                       a_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [MagW-1:0] mx, my, m;
      logic [LzW-1:0]  msb;
      mx = mag_of(in_x);
      my = mag_of(in_y);
      m  = (mx > my) ? mx : my;
      msb = '0;
      for (int i = 0; i < MagW; i++) begin
        if (m[i]) msb = LzW'(i);
      end
      a_msb  <= msb;
      a_zero <= (m == '0);
      a_y    <= in_y;
      a_x    <= in_x;
    end
  end

  // Stage B: scale so the larger magnitude lies in [2^29, 2^30), fold.
  logic signed [SW-1:0] b_x, b_y;
  logic [31:0]          b_z;
  logic                 b_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [MagW+31:0] xs, ys;
      logic signed [SW-1:0]    x0, y0;
      xs = (MagW+32)'(a_x);
      ys = (MagW+32)'(a_y);
      if (a_msb >= LzW'(29)) begin
        xs = xs >>> (a_msb - LzW'(29));
        ys = ys >>> (a_msb - LzW'(29));
      end else begin
        xs = xs <<< (LzW'(29) - a_msb);
        ys = ys <<< (LzW'(29) - a_msb);
      end
      x0 = SW'(xs);
      y0 = SW'(ys);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          b_x <= y0;
          b_y <= -x0;
          b_z <= 32'h40000000;
        end else begin
          b_x <= -y0;
          b_y <= x0;
          b_z <= 32'hC0000000;
        end
      end else begin
        b_x <= x0;
        b_y <= y0;
        b_z <= '0;
      end
      b_zero <= a_zero;
    end
  end

  logic signed [SW-1:0] cx [STEPS+1];
  logic signed [SW-1:0] cy [STEPS+1];
  logic [31:0]          cz [STEPS+1];
  logic                 cz0 [STEPS+1];

  assign cx[0]  = b_x;
  assign cy[0]  = b_y;
  assign cz[0]  = b_z;
  assign cz0[0] = b_zero;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic [4:0] K = 5'(i % MaxSteps);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> K);
          cy[i+1] <= cy[i] - (cx[i] >>> K);
          cz[i+1] <= cz[i] + atan_turn(K);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> K);
          cy[i+1] <= cy[i] + (cx[i] >>> K);
          cz[i+1] <= cz[i] - atan_turn(K);
        end
        cz0[i+1] <= cz0[i];
      end
    end
  end

  // Output rounding to the binary angle width.
  logic [31:0] zf;
  assign zf = cz0[STEPS] ? 32'h0 : cz[STEPS];

  if (ANGLE_WIDTH >= 32) begin : g_wide
    assign angle = ANGLE_WIDTH'(zf);
  end else begin : g_round
    logic [32:0] rr;
    assign rr    = {1'b0, zf} + (33'd1 << (31 - ANGLE_WIDTH));
    assign angle = rr[31 -: ANGLE_WIDTH];
  end

endmodule
`default_nettype wire

// ===== dv/tb_quaternion_to_euler_angles.sv =====
// ============================================================================
// tb_quaternion_to_euler_angles: self-checking bench for the quaternion
// to Euler angle converter.
// Directed corner quaternions, then random ones, are sent through the
// valid/ready channels; later random phases idle one side or both. A
// bit-true model of the fixed-point products, the square root and the
// vectoring CORDIC predicts each angle word; a scoreboard checks them in order.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_to_euler_angles;
  import q2e_pkg::*;

  localparam int CompWidth  = 16;
  localparam int AngWidth   = 16;
  localparam int CordSteps  = 16;
  localparam int FracBits   = CompWidth - 2;
  localparam int ProdShift  = (CompWidth > 30) ? 2 : 0;
  localparam int OneExp     = 2 * FracBits - ProdShift;
  localparam int Latency    = 21 + CordSteps;
  localparam int NumRandom  = 1750;
  localparam longint CycleLimit = 400000;

  // One expected output word of the converter.
  typedef struct packed {
    logic signed [AngWidth-1:0] roll;
    logic signed [AngWidth-1:0] pitch;
    logic signed [AngWidth-1:0] yaw;
    logic                       clamped;
  } euler_word_t;

  // Idle pattern of the run: which side pauses, and how often.
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_e;

  // --------------------------------------------------------------------------
  // Arithmetic helpers. Right shifts always floor, as the hardware does.
  // --------------------------------------------------------------------------
  function automatic longint fl_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint scaled_prod(longint a, longint b);
    return fl_shr(a * b, ProdShift);
  endfunction

  // Vectoring CORDIC on a 32-bit turn. Both arguments are normalized by one
  // shared power of two so that the larger magnitude sits in [2^29, 2^30).
  function automatic logic [31:0] turn_atan2(longint yv, longint xv);
    longint m, t, dx, dy;
    logic [31:0] ang;
    ang = '0;
    m = (abs64(xv) > abs64(yv)) ? abs64(xv) : abs64(yv);
    if (m == 0) return '0;
    while (m >= (64'sd1 <<< 30)) begin
      xv = fl_shr(xv, 1);
      yv = fl_shr(yv, 1);
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      xv = xv * 2;
      yv = yv * 2;
      m = m * 2;
    end
    // Fold the left half plane onto the right by a quarter turn.
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        ang = 32'h40000000;
      end else begin
        xv = -yv;
        yv = t;
        ang = 32'hC0000000;
      end
    end
    for (int i = 0; i < CordSteps; i++) begin
      dx = fl_shr(yv, i % 32);
      dy = fl_shr(xv, i % 32);
      if (yv > 0) begin
        xv = xv + dx;
        yv = yv - dy;
        ang = ang + atan_turn(5'(i % 32));
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        ang = ang - atan_turn(5'(i % 32));
      end
    end
    return ang;
  endfunction

  // Rounds the turn angle to the output width; a half turn wraps to -pi.
  function automatic logic [AngWidth-1:0] binary_angle(logic [31:0] ang);
    logic [32:0] r;
    if (AngWidth >= 32) return AngWidth'(ang);
    r = ({1'b0, ang} + (33'd1 << (31 - AngWidth))) >> (32 - AngWidth);
    return r[AngWidth-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Predicts roll, pitch, yaw and the clamp flag for one quaternion.
  function automatic euler_word_t euler_of_quat(logic signed [CompWidth-1:0] qw,
                                                logic signed [CompWidth-1:0] qx,
                                                logic signed [CompWidth-1:0] qy,
                                                logic signed [CompWidth-1:0] qz);
    longint w, x, y, z, one, rn, rd, yn, yd, s, sq;
    longint unsigned mag, q30, c;
    euler_word_t res;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    one = 64'sd1 <<< OneExp;
    rn = 2 * (scaled_prod(z, y) + scaled_prod(w, x));
    rd = one - 2 * (scaled_prod(x, x) + scaled_prod(y, y));
    yn = 2 * (scaled_prod(z, w) + scaled_prod(x, y));
    yd = 2 * (scaled_prod(w, w) + scaled_prod(x, x)) - one;
    s  = 2 * (scaled_prod(y, w) - scaled_prod(z, x));
    res.clamped = 1'b0;
    // A pitch sine past unit magnitude is pinned to +-1 and flagged.
    if (s > one) begin
      s = one;
      res.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one;
      res.clamped = 1'b1;
    end
    mag = abs64(s);
    if (OneExp <= 30) q30 = mag << (30 - OneExp);
    else q30 = (mag + (64'd1 << (OneExp - 31))) >> (OneExp - 30);
    if (q30 > (64'd1 << 30)) q30 = 64'd1 << 30;
    c = int_sqrt((64'd1 << 60) - q30 * q30);
    sq = (s < 0) ? -longint'(q30) : longint'(q30);
    res.roll  = binary_angle(turn_atan2(rn, rd));
    res.pitch = binary_angle(turn_atan2(sq, longint'(c)));
    res.yaw   = binary_angle(turn_atan2(yn, yd));
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: in-order queue of predicted angle words.
  // --------------------------------------------------------------------------
  class euler_scoreboard;
    euler_word_t pending[$];
    int errors;

    function void note_quat(logic signed [CompWidth-1:0] qw,
                            logic signed [CompWidth-1:0] qx,
                            logic signed [CompWidth-1:0] qy,
                            logic signed [CompWidth-1:0] qz);
      pending.push_back(euler_of_quat(qw, qx, qy, qz));
    endfunction

    function void check_angles(euler_word_t got);
      euler_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d clamp=%0b",
                 $realtime, got.roll, got.pitch, got.yaw, got.clamped);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.roll !== exp_w.roll) begin
        $display("%0t: roll expected %0d got %0d", $realtime, exp_w.roll, got.roll);
        errors++;
      end
      if (got.pitch !== exp_w.pitch) begin
        $display("%0t: pitch expected %0d got %0d", $realtime, exp_w.pitch, got.pitch);
        errors++;
      end
      if (got.yaw !== exp_w.yaw) begin
        $display("%0t: yaw expected %0d got %0d", $realtime, exp_w.yaw, got.yaw);
        errors++;
      end
      if (got.clamped !== exp_w.clamped) begin
        $display("%0t: pitch_clamped expected %0b got %0b", $realtime,
                 exp_w.clamped, got.clamped);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  q2e_quat_if  #(.COMPONENT_WIDTH(CompWidth)) quat ();
  q2e_euler_if #(.ANGLE_WIDTH(AngWidth))      euler ();

  quaternion_to_euler_angles #(
    .COMPONENT_WIDTH(CompWidth),
    .ANGLE_WIDTH    (AngWidth),
    .CORDIC_STEPS   (CordSteps)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .quat (quat.sink),
    .euler(euler.source)
  );

  euler_scoreboard angle_board = new();
  idle_phase_e idle_phase = PH_NONE;
  longint cycle_count = 0;

  initial begin
    quat.valid  = 1'b0;
    quat.comp_w = '0;
    quat.comp_x = '0;
    quat.comp_y = '0;
    quat.comp_z = '0;
    euler.ready = 1'b0;
  end

  // Watch both channels at the rising edge; a handshake there is one word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && quat.valid && quat.ready)
      angle_board.note_quat(quat.comp_w, quat.comp_x, quat.comp_y, quat.comp_z);
    if (!rst && euler.valid && euler.ready)
      angle_board.check_angles('{euler.roll_angle, euler.pitch_angle,
                                 euler.yaw_angle, euler.pitch_clamped});
    if (cycle_count > CycleLimit) begin
      $display("[quaternion_to_euler_angles] ERROR");
      $finish;
    end
  end

  // The receiver stalls according to the current phase, set at the falling edge.
  always @(negedge clk) begin
    if (rst) euler.ready <= 1'b0;
    else if (idle_phase == PH_SNK)
      euler.ready <= ($urandom_range(99) >= 46);
    else if (idle_phase == PH_BOTH)
      euler.ready <= ($urandom_range(99) >= 30);
    else
      euler.ready <= 1'b1;
  end

  // Presents one quaternion and holds it until accepted. Sender gaps are
  // placed before the word so that valid never drops between two words
  // that follow back to back.
  task automatic send_quat(logic [CompWidth-1:0] qw, logic [CompWidth-1:0] qx,
                           logic [CompWidth-1:0] qy, logic [CompWidth-1:0] qz);
    int idle_pct;
    idle_pct = (idle_phase == PH_SRC) ? 46 : ((idle_phase == PH_BOTH) ? 30 : 0);
    while ($urandom_range(99) < idle_pct) begin
      quat.valid <= 1'b0;
      @(negedge clk);
    end
    quat.valid  <= 1'b1;
    quat.comp_w <= qw;
    quat.comp_x <= qx;
    quat.comp_y <= qy;
    quat.comp_z <= qz;
    @(posedge clk);
    while (!quat.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random unit-ish quaternion: mostly near unit norm so that pitch sits
  // near the clamp boundary often; the rest is raw noise over all codes.
  task automatic send_random_quat();
    int kind;
    real a, b, c, d, n, sc;
    kind = $urandom_range(9);
    if (kind < 7) begin
      a = $itor($signed($urandom_range(65535) - 32768));
      b = $itor($signed($urandom_range(65535) - 32768));
      c = $itor($signed($urandom_range(65535) - 32768));
      d = $itor($signed($urandom_range(65535) - 32768));
      // Gimbal-lock neighborhood: make y*w - z*x close to one half.
      if (kind == 6) begin
        b = a / 8.0;
        c = a;
        d = -b;
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      sc = 16384.0 / n;
      send_quat(16'($rtoi(a * sc) + $signed($urandom_range(4)) - 2),
                16'($rtoi(b * sc) + $signed($urandom_range(4)) - 2),
                16'($rtoi(c * sc) + $signed($urandom_range(4)) - 2),
                16'($rtoi(d * sc) + $signed($urandom_range(4)) - 2));
    end else begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  localparam logic [15:0] One  = 16'sd16384;
  localparam logic [15:0] Half = 16'sd8192;
  localparam logic [15:0] Max  = 16'h7FFF;
  localparam logic [15:0] Min  = 16'h8000;
  localparam logic [15:0] Root = 16'sd11585;   // 1/sqrt(2) in Q2.14

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: identity, quarter and half turns about each axis,
    // pitch at exactly +-90 degrees, pitch sine past one (clamped both
    // ways), all-zero input where every atan2 y argument is zero, the
    // field extremes and an angle landing on pi.
    idle_phase = PH_NONE;
    send_quat(One, 0, 0, 0);
    send_quat(0, One, 0, 0);
    send_quat(0, 0, One, 0);
    send_quat(0, 0, 0, One);
    send_quat(Root, Root, 0, 0);
    send_quat(Root, 0, Root, 0);
    send_quat(Root, 0, -Root, 0);
    send_quat(Root, 0, 0, Root);
    send_quat(One, 0, One, 0);
    send_quat(One, 0, -One, 0);
    send_quat(Max, Max, Max, Max);
    send_quat(Min, Min, Min, Min);
    send_quat(Max, Min, Max, Min);
    send_quat(Min, Max, Min, Max);
    send_quat(0, 0, 0, 0);
    send_quat(-One, 0, 0, 0);
    send_quat(0, Root, 0, Root);
    send_quat(Half, Half, Half, Half);
    send_quat(Half, -Half, Half, -Half);
    send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    send_quat(Root, -Root, 0, 0);

    // Random part in four idle phases, one stretch without idling first.
    for (int p = 0; p < 4; p++) begin
      idle_phase = idle_phase_e'(p);
      for (int i = 0; i < NumRandom / 4; i++) send_random_quat();
    end
    quat.valid <= 1'b0;

    guard = 0;
    while (angle_board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (angle_board.errors == 0 && angle_board.pending.size() == 0) begin
      $display("[quaternion_to_euler_angles] OK");
    end else begin
      $display("[quaternion_to_euler_angles] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_quat_if.sv
hw/rtl/q2e_euler_if.sv
hw/rtl/q2e_isqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
dv/tb_quaternion_to_euler_angles.sv
